/* src/stt_pkg.sv */
// Package for the source text tokenizer: item types, token kinds, character codes
// and the keyword tables. It depends on nothing else.
package stt_pkg;

    // Width of offsets and lengths, and their saturation value.
    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Keyword count and the depth of the token queue.
    localparam int KW_NUM = 6;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    // Character codes that steer the scanner.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    typedef enum logic [4:0] {
        TK_EOF     = 5'd0,
        TK_NEWLINE = 5'd1,
        TK_INDENT  = 5'd2,
        TK_LPAREN  = 5'd3,
        TK_RPAREN  = 5'd4,
        TK_COLON   = 5'd5,
        TK_STRING  = 5'd6,
        TK_COMMENT = 5'd7,
        TK_IDENT   = 5'd8,
        TK_INTEGER = 5'd9,
        TK_TYPE    = 5'd10,
        TK_REPORT  = 5'd11,
        TK_NAME    = 5'd12,
        TK_PRINT   = 5'd13,
        TK_SKIP    = 5'd14,
        TK_LINE    = 5'd15,
        TK_BADCHAR = 5'd16,
        TK_UNTERM  = 5'd17
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [4:0]       token_kind;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] value_length;
        logic             last_of_run;
    } t_out_item;

    // One token inside the block.
    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } t_tok;

    // All tokens that one input byte causes, in order; cnt is 1 to 3.
    typedef struct packed {
        logic [1:0]     cnt;
        t_tok [2:0]     tok;
    } t_bundle;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] x);
        return (x == POS_MAX) ? POS_MAX : x + 1'b1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Keyword text, left justified in six bytes.
    function automatic logic [47:0] kw_text(input logic [2:0] k);
        logic [47:0] w;
        case (k)
            3'd0:    w = {"type", 16'h0};
            3'd1:    w = "report";
            3'd2:    w = {"name", 16'h0};
            3'd3:    w = {"print", 8'h0};
            3'd4:    w = {"skip", 16'h0};
            3'd5:    w = {"line", 16'h0};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd1:    n = 3'd6;
            3'd3:    n = 3'd5;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    // Drop every keyword that no longer matches after character c at index idx.
    function automatic logic [KW_NUM-1:0] narrow(input logic [KW_NUM-1:0] kwc,
                                                 input logic [POS_W-1:0] idx,
                                                 input logic [7:0] c);
        logic [KW_NUM-1:0] r;
        logic [47:0]       w;
        r = kwc;
        for (int k = 0; k < KW_NUM; k++) begin
            w = kw_text(3'(k));
            if (idx >= {{(POS_W-3){1'b0}}, kw_len(3'(k))}) begin
                r[k] = 1'b0;
            end else if (w[47 - 8*int'(idx[2:0]) -: 8] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // Close an identifier: the first keyword still matching at full length wins.
    function automatic t_tok close_ident(input logic [KW_NUM-1:0] kwc,
                                         input logic [POS_W-1:0] len,
                                         input logic [POS_W-1:0] start);
        t_tok t;
        logic hit;
        t.kind  = TK_IDENT;
        t.start = start;
        t.len   = len;
        hit     = 1'b0;
        for (int k = 0; k < KW_NUM; k++) begin
            if (!hit && kwc[k] && len == {{(POS_W-3){1'b0}}, kw_len(3'(k))}) begin
                t.kind = t_kind'(5'(TK_TYPE) + 5'(k));
                t.len  = '0;
                hit    = 1'b1;
            end
        end
        return t;
    endfunction

endpackage

/* src/stt_front.sv */
// Front end of the tokenizer: takes one byte a beat, runs the scanner state and
// gathers the tokens the byte causes into one bundle. Depends on stt_pkg.
module stt_front
    import stt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_bundle  o_bundle
);

    t_mode             r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_tstart, n_tstart;
    logic [POS_W-1:0]  r_tlen, n_tlen;
    logic [KW_NUM-1:0] r_kwc, n_kwc;

    logic       taken;
    logic       va, vb, vc, ve;
    t_tok       ta, tb, tc, te;
    logic [7:0] c;
    logic [1:0] k;
    logic       accept;

    assign c          = i_in.ch;
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Scanner: close of the open token, token of the byte itself, end of text.
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_tlen   = r_tlen;
        n_kwc    = r_kwc;
        taken    = 1'b0;
        va = 1'b0; vb = 1'b0; vc = 1'b0; ve = 1'b0;
        ta = '0;   tb = '0;   tc = '0;   te = '0;

        case (r_mode)
            MODE_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    n_kwc  = narrow(r_kwc, r_tlen, c);
                    n_tlen = sat_inc(r_tlen);
                    taken  = 1'b1;
                end else begin
                    va     = 1'b1;
                    ta     = close_ident(r_kwc, r_tlen, r_tstart);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c)) begin
                    n_tlen = sat_inc(r_tlen);
                    taken  = 1'b1;
                end else begin
                    va     = 1'b1;
                    ta     = '{TK_INTEGER, r_tstart, r_tlen};
                    n_mode = MODE_IDLE;
                end
            end
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    va     = 1'b1;
                    ta     = '{TK_STRING, r_tstart, r_tlen};
                    n_mode = MODE_IDLE;
                end else begin
                    n_tlen = sat_inc(r_tlen);
                end
                taken = 1'b1;
            end
            MODE_COMMENT: begin
                if (c == CH_NL) begin
                    va     = 1'b1;
                    ta     = '{TK_COMMENT, r_tstart, r_tlen};
                    n_mode = MODE_IDLE;
                end else begin
                    n_tlen = sat_inc(r_tlen);
                    taken  = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        // A byte not absorbed by an open token is classified on its own.
        if (!taken) begin
            if (c == CH_QUOTE || c == CH_HASH) begin
                n_mode   = (c == CH_QUOTE) ? MODE_STRING : MODE_COMMENT;
                n_tstart = sat_inc(r_pos);
                n_tlen   = '0;
            end else if (c == CH_NL) begin
                vb = 1'b1;
                tb = '{TK_NEWLINE, r_pos, '0};
            end else if (c == CH_TAB) begin
                vb = 1'b1;
                tb = '{TK_INDENT, r_pos, '0};
            end else if (c == CH_LPAREN) begin
                vb = 1'b1;
                tb = '{TK_LPAREN, r_pos, '0};
            end else if (c == CH_RPAREN) begin
                vb = 1'b1;
                tb = '{TK_RPAREN, r_pos, '0};
            end else if (c == CH_COLON) begin
                vb = 1'b1;
                tb = '{TK_COLON, r_pos, '0};
            end else if (c == CH_SPACE || c == CH_CR) begin
                vb = 1'b0;
            end else if (is_alpha(c)) begin
                n_mode   = MODE_IDENT;
                n_tstart = r_pos;
                n_tlen   = POS_W'(1);
                n_kwc    = narrow('1, '0, c);
            end else if (is_digit(c)) begin
                n_mode   = MODE_NUMBER;
                n_tstart = r_pos;
                n_tlen   = POS_W'(1);
            end else begin
                vb = 1'b1;
                tb = '{TK_BADCHAR, r_pos, '0};
            end
        end

        // The final byte closes whatever is open, reports the length, and resets.
        if (i_in.last) begin
            case (n_mode)
                MODE_IDENT: begin
                    vc = 1'b1;
                    tc = close_ident(n_kwc, n_tlen, n_tstart);
                end
                MODE_NUMBER: begin
                    vc = 1'b1;
                    tc = '{TK_INTEGER, n_tstart, n_tlen};
                end
                MODE_STRING: begin
                    vc = 1'b1;
                    tc = '{TK_UNTERM, n_tstart, n_tlen};
                end
                MODE_COMMENT: begin
                    vc = 1'b1;
                    tc = '{TK_COMMENT, n_tstart, n_tlen};
                end
                default: begin
                    vc = 1'b0;
                end
            endcase
            ve       = 1'b1;
            te       = '{TK_EOF, sat_inc(r_pos), '0};
            n_mode   = MODE_IDLE;
            n_pos    = '0;
            n_tstart = '0;
            n_tlen   = '0;
            n_kwc    = '1;
        end else begin
            n_pos = sat_inc(r_pos);
        end
    end

    // Pack the tokens in order; at most three are ever present for one byte.
    always_comb begin
        o_bundle = '0;
        k        = 2'd0;
        if (va) begin
            o_bundle.tok[k] = ta;
            k = k + 2'd1;
        end
        if (vb) begin
            o_bundle.tok[k] = tb;
            k = k + 2'd1;
        end
        if (vc) begin
            o_bundle.tok[k] = tc;
            k = k + 2'd1;
        end
        if (ve) begin
            o_bundle.tok[k] = te;
            k = k + 2'd1;
        end
        o_bundle.cnt = k;
        o_push       = accept && (k != 2'd0);
    end

    // Scanner state advances on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_tlen   <= '0;
            r_kwc    <= '1;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_tlen   <= n_tlen;
            r_kwc    <= n_kwc;
        end
    end

endmodule

/* src/stt_queue.sv */
// Short queue of token bundles between the front and back ends of the tokenizer.
// Depends on stt_pkg.
module stt_queue
    import stt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_data
);

    t_bundle       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_AW:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/stt_back.sv */
// Back end of the tokenizer: splits each bundle into single tokens and holds
// them in the output register until taken. Depends on stt_pkg.
module stt_back
    import stt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_bundle   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_out;
    logic       load, is_last;
    t_tok       cur;

    assign cur     = i_head.tok[r_idx];
    assign is_last = (r_idx == i_head.cnt - 2'd1);
    assign load    = i_head_valid && (!r_valid || i_out_ready);
    assign o_pop   = load && is_last;

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.token_kind   <= cur.kind;
            r_out.start_pos    <= cur.start;
            r_out.value_length <= cur.len;
            r_out.last_of_run  <= is_last;
        end
    end

    // Token index within the bundle and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* src/source_text_tokenizer.sv */
// Source text tokenizer, top level: front end, bundle queue and back end.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
// Usage: source bytes enter on the input channel (i_in_valid, o_in_ready,
// i_in with ch and last), one byte per beat. Tokens leave on the output
// channel (o_out_valid, i_out_ready, o_out with token_kind, start_pos,
// value_length and last_of_run), one token per beat.
// A token caused by an accepted byte is written into the bundle queue and then
// loaded into the output register, which drives o_out, once it is free.
// Throughput: one byte per cycle while each byte causes at most one token and
// the receiver takes each token. A byte that causes two or three tokens sends
// them out one after another at the output port; the four-entry bundle queue
// absorbs such bursts, and the input stalls only once the queue is full.
// Reset (i_rst_n low at a clock edge) returns the scanner to offset zero with
// no open token and empties the queue and the output register.
// When the receiver holds i_out_ready low, the current token stays on o_out,
// the queue fills, and then o_in_ready drops until space frees up.
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic    q_full, q_push, q_pop, q_valid;
    t_bundle q_wdata, q_rdata;

    stt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bundle   (q_wdata)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    stt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_rdata),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule
